// ----- rtl/core/sha1_pkg.sv -----
`timescale 1ns / 1ps

package sha1_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned DIG_WORDS = 5;
	localparam int unsigned WIN_DEPTH = 16;
	localparam int unsigned ROUNDS   = 80;

	localparam logic [WORD_W-1:0] SHA1_IV [DIG_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WORD_W-1:0] SHA1_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_COMP,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} phase_t;

	typedef struct packed {
		logic      put;
		byte_sel_t sel;
		logic [2:0] len_sel;
		logic      add_len;
		logic      load_work;
		logic      round;
		phase_t    phase;
		logic      fold;
		logic      clear;
		logic [2:0] emit_idx;
	} sha1_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} sha1_status_t;

endpackage

// ----- rtl/core/sha1_if.sv -----
`timescale 1ns / 1ps

// Message byte channel.
interface sha1_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, output data_byte, output has_byte, output last, input ready);
	modport sink (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

// Digest word channel.
interface sha1_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	modport source (output valid, output digest_word, output word_index, output digest_last,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input digest_last,
		output ready);
endinterface

// ----- rtl/core/sha1_ctrl.sv -----
`timescale 1ns / 1ps

module sha1_ctrl
	import sha1_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         msg_valid,
	input  logic         has_byte,
	input  logic         last,
	output logic         msg_ready,
	output logic         dig_valid,
	input  logic         dig_ready,
	output logic [2:0]   word_index,
	output logic         digest_last,
	input  sha1_status_t status,
	output sha1_cmd_t    cmd
);

	state_t     st_q, st_d;
	state_t     ret_q, ret_d;
	logic [6:0] round_q, round_d;
	logic [2:0] cnt_q, cnt_d;
	logic       msg_fire;
	logic       dig_fire;

	assign msg_fire = msg_valid && msg_ready;
	assign dig_fire = dig_valid && dig_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			cnt_q   <= '0;
		end else begin
			st_q    <= st_d;
			ret_q   <= ret_d;
			round_q <= round_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		ret_d     = ret_q;
		round_d   = round_q;
		cnt_d     = cnt_q;
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		cmd       = '0;
		cmd.emit_idx = cnt_q;
		if (round_q < 7'd20) begin
			cmd.phase = PH_CH;
		end else if (round_q < 7'd40) begin
			cmd.phase = PH_PAR1;
		end else if (round_q < 7'd60) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end
		case (st_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_fire) begin
					if (has_byte) begin
						cmd.put     = 1'b1;
						cmd.sel     = SEL_DATA;
						cmd.add_len = 1'b1;
					end
					if (has_byte && status.fill == 6'd63) begin
						cmd.load_work = 1'b1;
						st_d  = ST_COMP;
						ret_d = last ? ST_PAD80 : ST_IDLE;
					end else if (last) begin
						st_d = ST_PAD80;
					end
				end
			end
			ST_PAD80: begin
				cmd.put = 1'b1;
				cmd.sel = SEL_PAD;
				if (status.fill == 6'd63) begin
					cmd.load_work = 1'b1;
					st_d  = ST_COMP;
					ret_d = ST_PADZ;
				end else begin
					st_d = ST_PADZ;
				end
			end
			ST_PADZ: begin
				if (status.fill == 6'd56) begin
					st_d = ST_PADLEN;
				end else begin
					cmd.put = 1'b1;
					cmd.sel = SEL_ZERO;
					if (status.fill == 6'd63) begin
						cmd.load_work = 1'b1;
						st_d  = ST_COMP;
						ret_d = ST_PADZ;
					end
				end
			end
			ST_PADLEN: begin
				cmd.put     = 1'b1;
				cmd.sel     = SEL_LEN;
				cmd.len_sel = cnt_q;
				cnt_d       = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					cmd.load_work = 1'b1;
					st_d  = ST_COMP;
					ret_d = ST_EMIT;
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				round_d   = round_q + 7'd1;
				if (round_q == 7'(ROUNDS - 1)) begin
					round_d = '0;
					st_d    = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				st_d     = ret_q;
			end
			ST_EMIT: begin
				dig_valid = 1'b1;
				if (dig_fire) begin
					if (cnt_q == 3'(DIG_WORDS - 1)) begin
						cmd.clear = 1'b1;
						cnt_d     = '0;
						st_d      = ST_IDLE;
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign word_index  = cnt_q;
	assign digest_last = (cnt_q == 3'(DIG_WORDS - 1));

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> !msg_ready)
		else $error("digest word offered while message words are taken");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COMP) |-> (round_q < 7'(ROUNDS)))
		else $error("round counter out of range");

	a_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (status.fill == 6'd0))
		else $error("digest emitted with a partial block pending");

	a_round_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FOLD) |=> (round_q == 7'd0))
		else $error("round counter not rewound after compression");

endmodule

// ----- rtl/core/sha1_dp.sv -----
`timescale 1ns / 1ps

module sha1_dp
	import sha1_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  sha1_cmd_t    cmd,
	input  logic [7:0]   data_byte,
	output sha1_status_t status,
	output logic [31:0]  digest_word
);

	logic [5:0]        fill_q;
	logic [63:0]       len_q;
	logic [23:0]       acc_q;
	logic [WORD_W-1:0] win_q   [WIN_DEPTH];
	logic [WORD_W-1:0] chain_q [DIG_WORDS];
	logic [WORD_W-1:0] work_q  [DIG_WORDS];

	logic [7:0]        put_byte;
	logic [7:0]        len_byte;
	logic [WORD_W-1:0] sched_x;
	logic [WORD_W-1:0] sched_new;
	logic [WORD_W-1:0] new_word;
	logic              shift_en;
	logic [WORD_W-1:0] fn;
	logic [WORD_W-1:0] t_sum;
	logic [WORD_W-1:0] a, b, c, d, e;

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	// Bytes of the bit length go out most significant first.
	assign len_byte = 8'(len_q >> {~cmd.len_sel, 3'b000});

	always_comb begin
		case (cmd.sel)
			SEL_DATA: put_byte = data_byte;
			SEL_PAD:  put_byte = 8'h80;
			SEL_ZERO: put_byte = 8'h00;
			SEL_LEN:  put_byte = len_byte;
			default:  put_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (cmd.phase)
			PH_CH:   fn = (b & c) | (~b & d);
			PH_MAJ:  fn = (b & c) | (b & d) | (c & d);
			PH_PAR1: fn = b ^ c ^ d;
			PH_PAR2: fn = b ^ c ^ d;
			default: fn = b ^ c ^ d;
		endcase
	end

	// The window is a shift line: entry k holds W[t+k] during round t.
	assign sched_x   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign sched_new = {sched_x[30:0], sched_x[31]};
	assign t_sum     = {a[26:0], a[31:27]} + fn + e + SHA1_K[cmd.phase] + win_q[0];

	assign shift_en = cmd.round || (cmd.put && fill_q[1:0] == 2'd3);
	assign new_word = cmd.round ? sched_new : {acc_q, put_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < DIG_WORDS; i++) begin
				chain_q[i] <= SHA1_IV[i];
			end
		end else begin
			if (cmd.clear) begin
				fill_q <= '0;
				len_q  <= '0;
				for (int i = 0; i < DIG_WORDS; i++) begin
					chain_q[i] <= SHA1_IV[i];
				end
			end else begin
				if (cmd.put) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.add_len) begin
					len_q <= len_q + 64'd8;
				end
				if (cmd.fold) begin
					for (int i = 0; i < DIG_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			case (fill_q[1:0])
				2'd0:    acc_q[23:16] <= put_byte;
				2'd1:    acc_q[15:8]  <= put_byte;
				2'd2:    acc_q[7:0]   <= put_byte;
				default: acc_q        <= acc_q;
			endcase
		end
		if (shift_en) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_DEPTH-1] <= new_word;
		end
		if (cmd.load_work) begin
			for (int i = 0; i < DIG_WORDS; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			work_q[0] <= t_sum;
			work_q[1] <= a;
			work_q[2] <= {b[1:0], b[31:2]};
			work_q[3] <= c;
			work_q[4] <= d;
		end
	end

	always_comb begin
		case (cmd.emit_idx)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			3'd4:    digest_word = chain_q[4];
			default: digest_word = chain_q[0];
		endcase
	end

	assign status.fill = fill_q;

endmodule

// ----- rtl/core/sha1_message_digest_top.sv -----
`timescale 1ns / 1ps

// Channel  Role    Word                                   Handshake
// msg      sink    data_byte[7:0], has_byte, last         valid/ready
// digest   source  digest_word[31:0], word_index[2:0],    valid/ready
//                  digest_last
//
// A message word is taken while the block is idle; the 64th byte of a
// block starts a compression (80 rounds on one shared round unit, then the
// add into the chaining value). A last word pads one byte per cycle outside
// the compressions, compresses once or twice, and then offers the five
// digest words, one per cycle while digest.ready is high. The block takes
// no message word from the last word of a message until its fifth digest
// word has been taken; a stalled digest word holds.
// Reset (arst_n, asynchronous, active low) loads the initial chaining value
// and clears the byte count and the bit length.

module sha1_message_digest_top
	import sha1_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	sha1_msg_if.sink msg,
	sha1_dig_if.source digest
);

	// Command and status travel between the controller and the datapath only.
	sha1_cmd_t    cmd;
	sha1_status_t status;

	// The controller sequences byte loading, padding, rounds and digest output.
	sha1_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg.valid),
		.has_byte    (msg.has_byte),
		.last        (msg.last),
		.msg_ready   (msg.ready),
		.dig_valid   (digest.valid),
		.dig_ready   (digest.ready),
		.word_index  (digest.word_index),
		.digest_last (digest.digest_last),
		.status      (status),
		.cmd         (cmd)
	);

	// The datapath holds the block window, the working and chaining words
	// and the bit length, and performs one round per cycle.
	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.status      (status),
		.digest_word (digest.digest_word)
	);

endmodule
